// File: rtl/gwwb_pkg.sv
// Shared types, constants and state codes of the gray-world white balance unit.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gwwb_pkg;

   // Pixel bound is 2**MAX_PIXELS_LOG2; the tally must be able to hold the bound itself.
   localparam int MAX_PIXELS_LOG2 = 24;
   localparam int TALLY_W         = MAX_PIXELS_LOG2 + 1;

   localparam int SUM_W   = 32;
   localparam int PIX_W   = 8;
   localparam int AVG_W   = 16;
   localparam int GAIN_W  = 20;
   localparam int COUNT_W = 25;
   localparam int TOTAL_W = AVG_W + 2;

   // Divisor and partial remainder width of the shared divider.
   localparam int DIV_W  = (TALLY_W > TOTAL_W) ? TALLY_W : TOTAL_W;
   localparam int STEP_W = $clog2(GAIN_W + 1);

   localparam logic [STEP_W-1:0] AVG_STEPS  = STEP_W'(AVG_W);
   localparam logic [STEP_W-1:0] GAIN_STEPS = STEP_W'(GAIN_W);

   localparam logic [SUM_W-1:0]  SUM_MAX     = '1;
   localparam logic [GAIN_W-1:0] GAIN_MAX    = '1;
   localparam logic [AVG_W-1:0]  MIN_AVG_RST = AVG_W'(653);

   // Channel codes.
   localparam int CH_N = 3;
   localparam int CH_W = $clog2(CH_N);
   localparam logic [CH_W-1:0] CH_RED   = CH_W'(0);
   localparam logic [CH_W-1:0] CH_GREEN = CH_W'(1);
   localparam logic [CH_W-1:0] CH_BLUE  = CH_W'(2);
   localparam logic [CH_W-1:0] CH_LAST  = CH_BLUE;

   // Depth of the queue between the accumulator and the divide sequencer.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             last_pixel;
   } gwwb_req_type;

   typedef struct packed {
      logic [AVG_W-1:0]   avg_red;
      logic [AVG_W-1:0]   avg_green;
      logic [AVG_W-1:0]   avg_blue;
      logic [GAIN_W-1:0]  gain_red;
      logic [GAIN_W-1:0]  gain_green;
      logic [GAIN_W-1:0]  gain_blue;
      logic [COUNT_W-1:0] pixels_counted;
      logic               count_overflow;
   } gwwb_rsp_type;

   // Finished accumulation of one image, handed from front to back.
   typedef struct packed {
      logic [SUM_W-1:0]   red_sum;
      logic [SUM_W-1:0]   green_sum;
      logic [SUM_W-1:0]   blue_sum;
      logic [TALLY_W-1:0] tally;
      logic               overflow;
   } gwwb_snap_type;

   typedef struct packed {
      logic full;
      logic empty;
   } gwwb_q_stat_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [DIV_W-1:0]  dividend_hi;
      logic [GAIN_W-1:0] dividend_lo;
      logic [DIV_W-1:0]  divisor;
   } gwwb_div_req_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_LOAD,
      BK_WAIT,
      BK_EMIT
   } gwwb_bk_state_type;

endpackage

`default_nettype wire

// File: rtl/gray_world_white_balance_unit.sv
// Top level of the gray-world white balance unit.
// Depends on gwwb_pkg, gwwb_front, gwwb_queue and gwwb_back.
//
// The unit takes one 8-bit RGB pixel per cycle on the req channel and adds it
// into saturating 32-bit channel sums and a pixel tally (bounded at
// 2**MAX_PIXELS_LOG2; pixels past the bound are dropped and flag an overflow).
// The pixel marked last_pixel closes the image: its snapshot goes into a
// two-entry queue and the sums clear at once, so the next image streams in
// without a gap. A sequencer behind the queue works out the three channel
// averages (Q8.8, floored at min_average) and the three Q8.12 gains with one
// shared divider that produces one quotient bit per cycle. With the back end
// free, the sequencer takes the image from the queue, works out each average
// and then each gain through the divider and loads the output register; a
// gain that saturates skips the divider. Gains saturate at full scale,
// including a zero average. The req channel holds every pixel back while two
// finished images wait in the queue behind the one being worked on. The
// result sits in an output register until rsp_ready takes it.
// min_average is written through the csr channel and resets to 653; it must
// be written only while the unit is idle, which the unit does not enforce.
`default_nettype none

module gray_world_white_balance_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  gwwb_pkg::gwwb_req_type     req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output gwwb_pkg::gwwb_rsp_type     rsp_data,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [gwwb_pkg::AVG_W-1:0]  csr_data
);
   import gwwb_pkg::*;

   logic [AVG_W-1:0] min_average_ff;

   logic             req_accept;
   logic             push;
   gwwb_snap_type    push_data;
   logic             pop;
   gwwb_snap_type    pop_data;
   gwwb_q_stat_type  q_stat;

   // Hold pixels back only while the queue cannot take another image.
   assign req_ready  = ~q_stat.full;
   assign req_accept = req_valid & req_ready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_average_ff <= MIN_AVG_RST;
      end else if (csr_valid) begin
         min_average_ff <= csr_data;
      end
   end

   gwwb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req_data  (req_data),
      .push      (push),
      .push_data (push_data)
   );

   gwwb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (q_stat)
   );

   gwwb_back u_back (
      .clock       (clock),
      .reset       (reset),
      .min_average (min_average_ff),
      .q_stat      (q_stat),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_ready   (rsp_ready),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

// File: rtl/gwwb_front.sv
// Front end: accepts pixels, keeps saturating channel sums and the pixel tally.
// Depends on gwwb_pkg; pushes one snapshot per image into gwwb_queue.
`default_nettype none

module gwwb_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  accept,
   input  gwwb_pkg::gwwb_req_type req_data,
   output logic                 push,
   output gwwb_pkg::gwwb_snap_type push_data
);
   import gwwb_pkg::*;

   logic [SUM_W-1:0]   red_sum_ff, green_sum_ff, blue_sum_ff;
   logic [TALLY_W-1:0] tally_ff;
   logic               overflow_ff;

   logic [SUM_W:0]     red_add, green_add, blue_add;
   logic               room;
   gwwb_snap_type      acc;

   always_comb begin
      red_add   = {1'b0, red_sum_ff}   + (SUM_W+1)'(req_data.red);
      green_add = {1'b0, green_sum_ff} + (SUM_W+1)'(req_data.green);
      blue_add  = {1'b0, blue_sum_ff}  + (SUM_W+1)'(req_data.blue);
      // Tally never passes the bound, so its top bit set means the bound is reached.
      room = ~tally_ff[TALLY_W-1];
      if (room) begin
         acc.red_sum   = red_add[SUM_W]   ? SUM_MAX : red_add[SUM_W-1:0];
         acc.green_sum = green_add[SUM_W] ? SUM_MAX : green_add[SUM_W-1:0];
         acc.blue_sum  = blue_add[SUM_W]  ? SUM_MAX : blue_add[SUM_W-1:0];
         acc.tally     = tally_ff + TALLY_W'(1);
         acc.overflow  = overflow_ff | red_add[SUM_W] | green_add[SUM_W] | blue_add[SUM_W];
      end else begin
         acc.red_sum   = red_sum_ff;
         acc.green_sum = green_sum_ff;
         acc.blue_sum  = blue_sum_ff;
         acc.tally     = tally_ff;
         acc.overflow  = 1'b1;
      end
      push      = accept & req_data.last_pixel;
      push_data = acc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         blue_sum_ff  <= '0;
         tally_ff     <= '0;
         overflow_ff  <= 1'b0;
      end else if (accept) begin
         if (req_data.last_pixel) begin
            // Clear for the next image.
            red_sum_ff   <= '0;
            green_sum_ff <= '0;
            blue_sum_ff  <= '0;
            tally_ff     <= '0;
            overflow_ff  <= 1'b0;
         end else begin
            red_sum_ff   <= acc.red_sum;
            green_sum_ff <= acc.green_sum;
            blue_sum_ff  <= acc.blue_sum;
            tally_ff     <= acc.tally;
            overflow_ff  <= acc.overflow;
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/gwwb_queue.sv
// Short FIFO of image snapshots between the accumulator and the divide sequencer.
// Depends on gwwb_pkg for the snapshot type and depth.
`default_nettype none

module gwwb_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  gwwb_pkg::gwwb_snap_type push_data,
   input  wire                     pop,
   output gwwb_pkg::gwwb_snap_type pop_data,
   output gwwb_pkg::gwwb_q_stat_type stat
);
   import gwwb_pkg::*;

   gwwb_snap_type       entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [Q_CNT_W-1:0]  count_ff;

   function automatic logic [Q_PTR_W-1:0] ptr_next(input logic [Q_PTR_W-1:0] p);
      logic [Q_PTR_W-1:0] r;
      r = (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
      return r;
   endfunction

   assign pop_data   = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == Q_CNT_W'(Q_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + Q_CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - Q_CNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/gwwb_div.sv
// Iterative restoring divider, one quotient bit per cycle, shared by all six quotients.
// Depends on gwwb_pkg; caller guarantees the upper dividend part is below the divisor.
`default_nettype none

module gwwb_div (
   input  wire                        clock,
   input  wire                        reset,
   input  gwwb_pkg::gwwb_div_req_type req,
   output logic                       done,
   output logic [gwwb_pkg::GAIN_W-1:0] quotient
);
   import gwwb_pkg::*;

   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  divisor_ff;
   logic [GAIN_W-1:0] lo_ff;
   logic [GAIN_W-1:0] quot_ff, quot_in;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff, done_ff;

   logic [DIV_W:0]    trial, diff;
   logic              qbit;

   always_comb begin
      trial   = {rem_ff, lo_ff[GAIN_W-1]};
      diff    = trial - {1'b0, divisor_ff};
      qbit    = (trial >= {1'b0, divisor_ff});
      rem_in  = qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quot_in = {quot_ff[GAIN_W-2:0], qbit};
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff     <= req.dividend_hi;
         lo_ff      <= req.dividend_lo;
         divisor_ff <= req.divisor;
         quot_ff    <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         lo_ff   <= {lo_ff[GAIN_W-2:0], 1'b0};
         quot_ff <= quot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= req.steps;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/gwwb_back.sv
// Back end: per image, three averages then three gains (each through the shared divider
// unless saturated), then the result register. Depends on gwwb_pkg and gwwb_div.
`default_nettype none

module gwwb_back (
   input  wire                         clock,
   input  wire                         reset,
   input  wire [gwwb_pkg::AVG_W-1:0]   min_average,
   input  gwwb_pkg::gwwb_q_stat_type   q_stat,
   input  gwwb_pkg::gwwb_snap_type     pop_data,
   output logic                        pop,
   input  wire                         rsp_ready,
   output logic                        rsp_valid,
   output gwwb_pkg::gwwb_rsp_type      rsp_data
);
   import gwwb_pkg::*;

   gwwb_bk_state_type state_ff, state_in;

   gwwb_snap_type     snap_ff;
   logic [CH_W-1:0]   ch_ff;
   logic              gain_phase_ff;
   logic [AVG_W-1:0]  avg_ff  [CH_N];
   logic [GAIN_W-1:0] gain_ff [CH_N];
   logic [TOTAL_W-1:0] total_ff;
   logic              rsp_valid_ff;
   gwwb_rsp_type      rsp_data_ff;

   gwwb_div_req_type  div_req;
   logic              div_done;
   logic [GAIN_W-1:0] div_quot;

   logic [SUM_W-1:0]   sum_sel;
   logic [AVG_W-1:0]   avg_sel;
   logic [TOTAL_W-1:0] div3;
   logic               gain_sat;
   logic [AVG_W-1:0]   avg_floored;
   logic               ch_step;
   logic               emit;

   gwwb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      case (ch_ff)
         CH_RED:   sum_sel = snap_ff.red_sum;
         CH_GREEN: sum_sel = snap_ff.green_sum;
         default:  sum_sel = snap_ff.blue_sum;
      endcase
      avg_sel = avg_ff[ch_ff];
      div3    = {2'b00, avg_sel} + {1'b0, avg_sel, 1'b0};
      // Quotient reaches 2**20 exactly when total >= 256 * 3 * avg; covers avg of zero too.
      gain_sat = ({8'd0, total_ff} >= {div3, 8'd0});
      avg_floored = (div_quot[AVG_W-1:0] < min_average) ? min_average : div_quot[AVG_W-1:0];

      div_req.start = 1'b0;
      if (gain_phase_ff) begin
         div_req.steps       = GAIN_STEPS;
         div_req.dividend_hi = DIV_W'(total_ff[TOTAL_W-1:8]);
         div_req.dividend_lo = {total_ff[7:0], 12'd0};
         div_req.divisor     = DIV_W'(div3);
      end else begin
         div_req.steps       = AVG_STEPS;
         div_req.dividend_hi = DIV_W'(sum_sel[SUM_W-1:8]);
         div_req.dividend_lo = {sum_sel[7:0], 12'd0};
         div_req.divisor     = DIV_W'(snap_ff.tally);
      end

      state_in = state_ff;
      pop      = 1'b0;
      ch_step  = 1'b0;
      emit     = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop      = 1'b1;
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            if (gain_phase_ff && gain_sat) begin
               ch_step = 1'b1;
               if (ch_ff == CH_LAST) begin
                  state_in = BK_EMIT;
               end
            end else begin
               div_req.start = 1'b1;
               state_in      = BK_WAIT;
            end
         end
         BK_WAIT: begin
            if (div_done) begin
               ch_step  = 1'b1;
               state_in = (gain_phase_ff && ch_ff == CH_LAST) ? BK_EMIT : BK_LOAD;
            end
         end
         BK_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               emit     = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequencer position and result handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         ch_ff         <= CH_RED;
         gain_phase_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            ch_ff         <= CH_RED;
            gain_phase_ff <= 1'b0;
         end else if (ch_step) begin
            if (ch_ff == CH_LAST) begin
               ch_ff         <= CH_RED;
               gain_phase_ff <= 1'b1;
            end else begin
               ch_ff <= ch_ff + CH_W'(1);
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         snap_ff <= pop_data;
      end
      if (state_ff == BK_LOAD && gain_phase_ff && gain_sat) begin
         gain_ff[ch_ff] <= GAIN_MAX;
      end
      if (state_ff == BK_WAIT && div_done) begin
         if (gain_phase_ff) begin
            gain_ff[ch_ff] <= div_quot;
         end else begin
            avg_ff[ch_ff] <= avg_floored;
            if (ch_ff == CH_LAST) begin
               total_ff <= {2'b00, avg_ff[CH_RED]} + {2'b00, avg_ff[CH_GREEN]}
                           + {2'b00, avg_floored};
            end
         end
      end
      if (emit) begin
         rsp_data_ff.avg_red        <= avg_ff[CH_RED];
         rsp_data_ff.avg_green      <= avg_ff[CH_GREEN];
         rsp_data_ff.avg_blue       <= avg_ff[CH_BLUE];
         rsp_data_ff.gain_red       <= gain_ff[CH_RED];
         rsp_data_ff.gain_green     <= gain_ff[CH_GREEN];
         rsp_data_ff.gain_blue      <= gain_ff[CH_BLUE];
         rsp_data_ff.pixels_counted <= COUNT_W'(snap_ff.tally);
         rsp_data_ff.count_overflow <= snap_ff.overflow;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: rtl/gwwb_checker.sv
// Port-level checks of the result channel, bound to the top level.
// Depends on gwwb_pkg and gray_world_white_balance_unit.
`default_nettype none

module gwwb_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    rsp_valid,
   input wire                    rsp_ready,
   input gwwb_pkg::gwwb_rsp_type rsp_data
);
   import gwwb_pkg::*;

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No result right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A zero average always gives a full-scale gain.
   a_zero_avg_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.avg_red != '0 || rsp_data.gain_red == GAIN_MAX)
                 && (rsp_data.avg_green != '0 || rsp_data.gain_green == GAIN_MAX)
                 && (rsp_data.avg_blue != '0 || rsp_data.gain_blue == GAIN_MAX))
      else $error("zero average without saturated gain");

   // Equal red and green averages give equal red and green gains.
   a_equal_gain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.avg_red == rsp_data.avg_green
      |-> rsp_data.gain_red == rsp_data.gain_green)
      else $error("equal averages with different gains");

endmodule

bind gray_world_white_balance_unit gwwb_checker u_gwwb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
